// ===== src/dcnt_pkg.sv =====
`timescale 1ns / 1ps

package dcnt_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
    localparam logic [15:0] HALF_MASK     = 16'hFFFF;
    localparam logic [7:0]  CONTROL_RESET = 8'h20;
    localparam logic [7:0]  CONTROL_KEEP  = 8'hEF;
    localparam logic [7:0]  PRESC_WRAP16  = 8'd15;
    localparam logic [7:0]  PRESC_WRAP256 = 8'd255;

    localparam int CB_ONESHOT  = 0;
    localparam int CB_SIZE32   = 1;
    localparam int CB_PRESC_LO = 2;
    localparam int CB_PRESC_HI = 3;
    localparam int CB_IE       = 5;
    localparam int CB_PERIODIC = 6;
    localparam int CB_ENABLE   = 7;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_LOAD   = 3'd0,
        REG_VALUE  = 3'd1,
        REG_CTRL   = 3'd2,
        REG_INTCLR = 3'd3,
        REG_RIS    = 3'd4,
        REG_MIS    = 3'd5,
        REG_BGLOAD = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        PRESC_DIV1   = 2'd0,
        PRESC_DIV16  = 2'd1
    } presc_t;

    typedef struct packed {
        logic        tick;
        logic        wr;
        logic [2:0]  idx;
        logic [31:0] wdata;
    } dcnt_acc_t;

endpackage

// ===== src/dcnt_timer.sv =====
`timescale 1ns / 1ps

module dcnt_timer #(
    parameter int COUNT_WIDTH = dcnt_pkg::COUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dcnt_pkg::dcnt_acc_t acc,
    output logic [31:0]        rdata,
    output logic               irq_next
);

    logic [31:0]            load_reg, load_next;
    logic [31:0]            bgload_reg, bgload_next;
    logic [7:0]             ctrl_reg, ctrl_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             presc_reg, presc_next;
    logic                   pend_reg, pend_next;

    logic [COUNT_WIDTH-1:0] mask_cur;
    logic [COUNT_WIDTH-1:0] mask_wr;
    logic [COUNT_WIDTH-1:0] count_m;
    logic [COUNT_WIDTH-1:0] step_count;
    logic                   step_pend;
    logic                   wrap;

    always_comb
    begin
        mask_cur = ctrl_reg[dcnt_pkg::CB_SIZE32] ? '1
                                                 : COUNT_WIDTH'(dcnt_pkg::HALF_MASK);
        mask_wr  = acc.wdata[dcnt_pkg::CB_SIZE32] ? '1
                                                  : COUNT_WIDTH'(dcnt_pkg::HALF_MASK);
        count_m  = count_reg & mask_cur;
    end

    always_comb
    begin
        unique case (dcnt_pkg::presc_t'(ctrl_reg[dcnt_pkg::CB_PRESC_HI:dcnt_pkg::CB_PRESC_LO]))
            dcnt_pkg::PRESC_DIV1:  wrap = 1'b1;
            dcnt_pkg::PRESC_DIV16: wrap = (presc_reg >= dcnt_pkg::PRESC_WRAP16);
            default:               wrap = (presc_reg == dcnt_pkg::PRESC_WRAP256);
        endcase
    end

    always_comb
    begin
        step_pend  = pend_reg;
        step_count = count_m;
        if (count_m != '0)
        begin
            step_count = count_m - COUNT_WIDTH'(1);
            if (count_m == COUNT_WIDTH'(1))
            begin
                step_pend = 1'b1;
            end
        end
        else if (!ctrl_reg[dcnt_pkg::CB_ONESHOT])
        begin
            step_count = (ctrl_reg[dcnt_pkg::CB_PERIODIC]
                          ? load_reg[COUNT_WIDTH-1:0]
                          : dcnt_pkg::ALL_ONES[COUNT_WIDTH-1:0]) & mask_cur;
        end
    end

    always_comb
    begin
        load_next   = load_reg;
        bgload_next = bgload_reg;
        ctrl_next   = ctrl_reg;
        count_next  = count_reg;
        presc_next  = presc_reg;
        pend_next   = pend_reg;
        if (acc.tick && ctrl_reg[dcnt_pkg::CB_ENABLE])
        begin
            if (wrap)
            begin
                presc_next = '0;
                count_next = step_count;
                pend_next  = step_pend;
            end
            else
            begin
                presc_next = presc_reg + 8'd1;
            end
        end
        else if (acc.wr)
        begin
            unique case (dcnt_pkg::reg_idx_t'(acc.idx))
                dcnt_pkg::REG_LOAD:
                begin
                    load_next   = acc.wdata;
                    bgload_next = acc.wdata;
                    count_next  = acc.wdata[COUNT_WIDTH-1:0] & mask_cur;
                    presc_next  = '0;
                end
                dcnt_pkg::REG_CTRL:
                begin
                    ctrl_next  = acc.wdata[7:0] & dcnt_pkg::CONTROL_KEEP;
                    count_next = load_reg[COUNT_WIDTH-1:0] & mask_wr;
                    presc_next = '0;
                end
                dcnt_pkg::REG_INTCLR:
                begin
                    pend_next = 1'b0;
                end
                dcnt_pkg::REG_BGLOAD:
                begin
                    load_next   = acc.wdata;
                    bgload_next = acc.wdata;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign irq_next = ctrl_next[dcnt_pkg::CB_IE] & pend_next;

    always_comb
    begin
        unique case (dcnt_pkg::reg_idx_t'(acc.idx))
            dcnt_pkg::REG_LOAD:   rdata = load_reg;
            dcnt_pkg::REG_VALUE:  rdata = 32'(count_m);
            dcnt_pkg::REG_CTRL:   rdata = {24'd0, ctrl_reg};
            dcnt_pkg::REG_RIS:    rdata = {31'd0, pend_reg};
            dcnt_pkg::REG_MIS:    rdata = {31'd0, ctrl_reg[dcnt_pkg::CB_IE] & pend_reg};
            dcnt_pkg::REG_BGLOAD: rdata = bgload_reg;
            default:              rdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg   <= '0;
            bgload_reg <= '0;
            ctrl_reg   <= dcnt_pkg::CONTROL_RESET;
            count_reg  <= '1;
            presc_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            load_reg   <= load_next;
            bgload_reg <= bgload_next;
            ctrl_reg   <= ctrl_next;
            count_reg  <= count_next;
            presc_reg  <= presc_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// ===== src/dual_down_counter_timer_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Fields
// in       in_valid / in_stall  operation, timer_select, reg_index, write_data
// out      out_valid / out_stall read_data, irq_first, irq_second, irq_combined
//
// One item per cycle while in_stall is low; the accepting edge registers its result.
// Timer state updates at the accepting edge; the result goes to an output register.
// A two-entry output buffer (output register plus skid entry) decouples the sides;
// in_stall rises only when both entries hold results.
// Reset is asynchronous, active low, and brings both timers to their register defaults.

module dual_down_counter_timer_unit #(
    parameter int COUNT_WIDTH = dcnt_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic        timer_select,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        irq_first,
    output logic        irq_second,
    output logic        irq_combined
);

    logic                accept;
    logic                out_take;
    logic                is_tick;
    logic                is_read;
    logic                is_write;
    dcnt_pkg::dcnt_acc_t acc0;
    dcnt_pkg::dcnt_acc_t acc1;
    logic [31:0]         rdata0;
    logic [31:0]         rdata1;
    logic                irq0;
    logic                irq1;
    logic [31:0]         res_rdata;

    logic                out_valid_reg;
    logic [31:0]         out_rdata_reg;
    logic                out_irq0_reg;
    logic                out_irq1_reg;
    logic                skid_valid_reg;
    logic [31:0]         skid_rdata_reg;
    logic                skid_irq0_reg;
    logic                skid_irq1_reg;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        is_tick  = 1'b0;
        is_read  = 1'b0;
        is_write = 1'b0;
        unique case (dcnt_pkg::op_t'(operation))
            dcnt_pkg::OP_TICK:  is_tick  = 1'b1;
            dcnt_pkg::OP_READ:  is_read  = 1'b1;
            dcnt_pkg::OP_WRITE: is_write = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        acc0.tick  = accept && is_tick;
        acc0.wr    = accept && is_write && !timer_select;
        acc0.idx   = reg_index;
        acc0.wdata = write_data;
        acc1.tick  = accept && is_tick;
        acc1.wr    = accept && is_write && timer_select;
        acc1.idx   = reg_index;
        acc1.wdata = write_data;
    end

    dcnt_timer #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_timer0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc0),
        .rdata    (rdata0),
        .irq_next (irq0)
    );

    dcnt_timer #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_timer1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc1),
        .rdata    (rdata1),
        .irq_next (irq1)
    );

    assign res_rdata = is_read ? (timer_select ? rdata1 : rdata0) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (!out_valid_reg || out_take))
        begin
            out_rdata_reg <= res_rdata;
            out_irq0_reg  <= irq0;
            out_irq1_reg  <= irq1;
        end
        else if (skid_valid_reg && out_take)
        begin
            out_rdata_reg <= skid_rdata_reg;
            out_irq0_reg  <= skid_irq0_reg;
            out_irq1_reg  <= skid_irq1_reg;
        end
        if (accept && out_valid_reg && !out_take)
        begin
            skid_rdata_reg <= res_rdata;
            skid_irq0_reg  <= irq0;
            skid_irq1_reg  <= irq1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = out_rdata_reg;
    assign irq_first    = out_irq0_reg;
    assign irq_second   = out_irq1_reg;
    assign irq_combined = out_irq0_reg | out_irq1_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output result");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled while output was free");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall && !skid_valid_reg && !accept))
        else $error("output result dropped without being taken");
`endif

endmodule
